// File: sv/rrp_pkg.sv
`timescale 1ns / 1ps

package rrp_pkg;

    localparam int BYTE_W     = 8;
    localparam int COUNT_W    = 8;
    localparam int TOKLEN_W   = 16;
    localparam int ACC_W      = 17;
    localparam int CFG_DATA_W = 16;

    localparam logic [ACC_W-1:0] ACC_MAX = 17'd131071;

    localparam logic [BYTE_W-1:0] CH_STAR   = 8'h2A;
    localparam logic [BYTE_W-1:0] CH_DOLLAR = 8'h24;
    localparam logic [BYTE_W-1:0] CH_CR     = 8'h0D;
    localparam logic [BYTE_W-1:0] CH_LF     = 8'h0A;
    localparam logic [BYTE_W-1:0] CH_MINUS  = 8'h2D;
    localparam logic [BYTE_W-1:0] CH_ZERO   = 8'h30;
    localparam logic [BYTE_W-1:0] CH_NINE   = 8'h39;

    localparam logic [COUNT_W-1:0]  TOK_LIMIT_RST = 8'd16;
    localparam logic [TOKLEN_W-1:0] MAX_LEN_RST   = 16'd16384;

    typedef enum logic
    {
        REG_TOK_LIMIT  = 1'b0,
        REG_MAX_LENGTH = 1'b1
    } cfg_index_t;

    typedef enum logic [1:0]
    {
        KIND_PAYLOAD    = 2'd0,
        KIND_TOKEN_DONE = 2'd1,
        KIND_EMPTY      = 2'd2,
        KIND_ERROR      = 2'd3
    } kind_t;

    typedef enum logic [2:0]
    {
        ERR_NO_STAR    = 3'd0,
        ERR_NO_DOLLAR  = 3'd1,
        ERR_BAD_SYNTAX = 3'd2,
        ERR_TOO_MANY   = 3'd3,
        ERR_BAD_LENGTH = 3'd4
    } err_t;

    typedef struct packed
    {
        kind_t                kind;
        logic [BYTE_W-1:0]    data_byte;
        logic [COUNT_W-1:0]   token_index;
        logic [TOKLEN_W-1:0]  token_length;
        logic                 last_token;
        logic [COUNT_W-1:0]   cmd_tokens;
        err_t                 error_code;
    } result_t;

endpackage

// File: sv/rrp_parser.sv
`timescale 1ns / 1ps

module rrp_parser #(
    parameter int LENGTH_BITS = 16
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             step,
    input  logic [rrp_pkg::BYTE_W-1:0]       in_byte,
    input  logic [rrp_pkg::COUNT_W-1:0]      tok_limit,
    input  logic [rrp_pkg::TOKLEN_W-1:0]     max_length,
    output logic                             res_valid,
    output rrp_pkg::result_t                 res
);

    // Length registers never need more than the 16-bit result field.
    localparam int LEN_W = (LENGTH_BITS < rrp_pkg::TOKLEN_W) ? LENGTH_BITS
                                                             : rrp_pkg::TOKLEN_W;
    localparam logic [rrp_pkg::ACC_W-1:0] LEN_LIM =
        rrp_pkg::ACC_W'((64'd1 << LEN_W) - 64'd1);
    localparam int MUL_W = rrp_pkg::ACC_W + 4;

    typedef enum logic [3:0]
    {
        PH_IDLE,
        PH_RESYNC,
        PH_COUNT,
        PH_COUNT_LF,
        PH_DOLLAR,
        PH_LEN,
        PH_LEN_LF,
        PH_PAYLOAD,
        PH_TRAIL1,
        PH_TRAIL2
    } phase_t;

    phase_t                          phase_reg, phase_next;
    logic                            minus_reg, minus_next;
    logic [rrp_pkg::ACC_W-1:0]       acc_reg, acc_next;
    logic                            digit_reg, digit_next;
    logic [rrp_pkg::COUNT_W-1:0]     tdecl_reg, tdecl_next;
    logic [rrp_pkg::COUNT_W-1:0]     tpos_reg, tpos_next;
    logic [LEN_W-1:0]                remain_reg, remain_next;
    logic [LEN_W-1:0]                clen_reg, clen_next;

    logic                            is_digit;
    logic [MUL_W-1:0]                acc_mul;
    logic [rrp_pkg::ACC_W-1:0]       acc_digit;
    logic                            num_absorb;
    logic                            num_minus;
    logic                            num_cr;
    logic [rrp_pkg::COUNT_W:0]       tpos_inc;
    logic                            last;

    assign is_digit  = (in_byte >= rrp_pkg::CH_ZERO) && (in_byte <= rrp_pkg::CH_NINE);
    assign acc_mul   = (MUL_W'(acc_reg) << 3) + (MUL_W'(acc_reg) << 1)
                     + MUL_W'(in_byte - rrp_pkg::CH_ZERO);
    assign acc_digit = (acc_mul > MUL_W'(rrp_pkg::ACC_MAX)) ? rrp_pkg::ACC_MAX
                                                            : acc_mul[rrp_pkg::ACC_W-1:0];
    assign num_minus  = (in_byte == rrp_pkg::CH_MINUS) && !digit_reg;
    assign num_absorb = is_digit || num_minus;
    assign num_cr     = (in_byte == rrp_pkg::CH_CR);
    assign tpos_inc   = {1'b0, tpos_reg} + 9'd1;
    assign last       = tpos_inc >= {1'b0, tdecl_reg};

    always_comb
    begin
        phase_next  = phase_reg;
        minus_next  = minus_reg;
        acc_next    = acc_reg;
        digit_next  = digit_reg;
        tdecl_next  = tdecl_reg;
        tpos_next   = tpos_reg;
        remain_next = remain_reg;
        clen_next   = clen_reg;
        res_valid   = 1'b0;
        res         = '0;

        case (phase_reg)
            PH_RESYNC:
            begin
                if (in_byte == rrp_pkg::CH_STAR)
                begin
                    minus_next = 1'b0;
                    acc_next   = '0;
                    digit_next = 1'b0;
                    phase_next = PH_COUNT;
                end
            end
            PH_COUNT, PH_LEN:
            begin
                if (is_digit)
                begin
                    acc_next   = acc_digit;
                    digit_next = 1'b1;
                end
                else if (num_minus)
                begin
                    minus_next = 1'b1;
                    digit_next = 1'b1;
                end
                else if (num_cr)
                begin
                    phase_next = (phase_reg == PH_COUNT) ? PH_COUNT_LF : PH_LEN_LF;
                end
                if (!num_absorb && !num_cr)
                begin
                    res_valid      = 1'b1;
                    res.kind       = rrp_pkg::KIND_ERROR;
                    res.error_code = rrp_pkg::ERR_BAD_SYNTAX;
                    phase_next     = PH_RESYNC;
                end
            end
            PH_COUNT_LF:
            begin
                res_valid = 1'b1;
                if (in_byte != rrp_pkg::CH_LF)
                begin
                    res.kind       = rrp_pkg::KIND_ERROR;
                    res.error_code = rrp_pkg::ERR_BAD_SYNTAX;
                    phase_next     = PH_RESYNC;
                end
                else if (minus_reg || (acc_reg == '0))
                begin
                    res.kind   = rrp_pkg::KIND_EMPTY;
                    phase_next = PH_IDLE;
                end
                else if (acc_reg > rrp_pkg::ACC_W'(tok_limit))
                begin
                    res.kind       = rrp_pkg::KIND_ERROR;
                    res.error_code = rrp_pkg::ERR_TOO_MANY;
                    phase_next     = PH_RESYNC;
                end
                else
                begin
                    res_valid  = 1'b0;
                    tdecl_next = acc_reg[rrp_pkg::COUNT_W-1:0];
                    tpos_next  = '0;
                    phase_next = PH_DOLLAR;
                end
            end
            PH_DOLLAR:
            begin
                if (in_byte != rrp_pkg::CH_DOLLAR)
                begin
                    res_valid      = 1'b1;
                    res.kind       = rrp_pkg::KIND_ERROR;
                    res.error_code = rrp_pkg::ERR_NO_DOLLAR;
                    phase_next     = PH_RESYNC;
                end
                else
                begin
                    minus_next = 1'b0;
                    acc_next   = '0;
                    digit_next = 1'b0;
                    phase_next = PH_LEN;
                end
            end
            PH_LEN_LF:
            begin
                if (in_byte != rrp_pkg::CH_LF)
                begin
                    res_valid      = 1'b1;
                    res.kind       = rrp_pkg::KIND_ERROR;
                    res.error_code = rrp_pkg::ERR_BAD_SYNTAX;
                    phase_next     = PH_RESYNC;
                end
                else if ((minus_reg && (acc_reg != '0))
                         || (acc_reg > rrp_pkg::ACC_W'(max_length))
                         || (acc_reg > LEN_LIM))
                begin
                    res_valid      = 1'b1;
                    res.kind       = rrp_pkg::KIND_ERROR;
                    res.error_code = rrp_pkg::ERR_BAD_LENGTH;
                    phase_next     = PH_RESYNC;
                end
                else
                begin
                    clen_next   = acc_reg[LEN_W-1:0];
                    remain_next = acc_reg[LEN_W-1:0];
                    phase_next  = (acc_reg == '0) ? PH_TRAIL1 : PH_PAYLOAD;
                end
            end
            PH_PAYLOAD:
            begin
                res_valid       = 1'b1;
                res.kind        = rrp_pkg::KIND_PAYLOAD;
                res.data_byte   = in_byte;
                res.token_index = tpos_reg;
                res.cmd_tokens  = tdecl_reg;
                remain_next     = remain_reg - LEN_W'(1);
                if (remain_reg == LEN_W'(1))
                begin
                    phase_next = PH_TRAIL1;
                end
            end
            PH_TRAIL1:
            begin
                phase_next = PH_TRAIL2;
            end
            PH_TRAIL2:
            begin
                res_valid        = 1'b1;
                res.kind         = rrp_pkg::KIND_TOKEN_DONE;
                res.token_index  = tpos_reg;
                res.token_length = rrp_pkg::TOKLEN_W'(clen_reg);
                res.last_token   = last;
                res.cmd_tokens   = tdecl_reg;
                tpos_next        = tpos_inc[rrp_pkg::COUNT_W-1:0];
                phase_next       = last ? PH_IDLE : PH_DOLLAR;
            end
            default:
            begin
                if (in_byte == rrp_pkg::CH_STAR)
                begin
                    minus_next = 1'b0;
                    acc_next   = '0;
                    digit_next = 1'b0;
                    phase_next = PH_COUNT;
                end
                else
                begin
                    res_valid      = 1'b1;
                    res.kind       = rrp_pkg::KIND_ERROR;
                    res.error_code = rrp_pkg::ERR_NO_STAR;
                    phase_next     = PH_RESYNC;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_IDLE;
            minus_reg  <= 1'b0;
            acc_reg    <= '0;
            digit_reg  <= 1'b0;
            tdecl_reg  <= '0;
            tpos_reg   <= '0;
            remain_reg <= '0;
            clen_reg   <= '0;
        end
        else if (step)
        begin
            phase_reg  <= phase_next;
            minus_reg  <= minus_next;
            acc_reg    <= acc_next;
            digit_reg  <= digit_next;
            tdecl_reg  <= tdecl_next;
            tpos_reg   <= tpos_next;
            remain_reg <= remain_next;
            clen_reg   <= clen_next;
        end
    end

endmodule

// File: sv/rrp_out_fifo.sv
`timescale 1ns / 1ps

module rrp_out_fifo (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  rrp_pkg::result_t  push_data,
    output logic              has_space,
    output logic              out_valid,
    input  logic              out_stall,
    output rrp_pkg::result_t  out_data
);

    // Two entries: the second one lets the parser push another word
    // while the output side is stalled.
    rrp_pkg::result_t  entry_reg [2];
    logic              wr_ptr_reg, wr_ptr_next;
    logic              rd_ptr_reg, rd_ptr_next;
    logic [1:0]        count_reg, count_next;
    logic              pop;

    assign has_space = (count_reg != 2'd2);
    assign out_valid = (count_reg != 2'd0);
    assign pop       = out_valid && !out_stall;
    assign out_data  = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop  ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// File: sv/resp_request_parser_unit.sv
`timescale 1ns / 1ps

// Byte-serial parser for RESP2 requests: one byte is taken per clock unless
// the input stalls, and each byte gives at most one result word (payload
// byte, token done, empty command or error). A byte is held in the input
// register, where the parse state machine decodes it, and then lands in a
// two-word output queue; throughput is one byte per cycle for as long as the
// output side keeps taking words, and the input stalls only when both queue
// words are full. After an error the parser drops bytes until the next '*'.
// The two limit registers should be written only while the parser is idle.
module resp_request_parser_unit #(
    parameter int LENGTH_BITS = 16
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic                              cfg_index,
    input  logic [rrp_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic [7:0]                        in_byte,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic [1:0]                        kind,
    output logic [7:0]                        data_byte,
    output logic [7:0]                        token_index,
    output logic [15:0]                       token_length,
    output logic                              last_token,
    output logic [7:0]                        cmd_tokens,
    output logic [2:0]                        error_code
);

    logic [rrp_pkg::COUNT_W-1:0]   tok_limit_reg;
    logic [rrp_pkg::TOKLEN_W-1:0]  max_length_reg;
    logic                          in_full_reg, in_full_next;
    logic [rrp_pkg::BYTE_W-1:0]    in_byte_reg;
    logic                          has_space;
    logic                          step;
    logic                          res_valid;
    rrp_pkg::result_t              res;
    rrp_pkg::result_t              out_data;

    assign step     = in_full_reg && has_space;
    assign in_stall = in_full_reg && !has_space;

    always_comb
    begin
        in_full_next = in_full_reg;
        if (in_valid && !in_stall)
        begin
            in_full_next = 1'b1;
        end
        else if (step)
        begin
            in_full_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_full_reg    <= 1'b0;
            tok_limit_reg  <= rrp_pkg::TOK_LIMIT_RST;
            max_length_reg <= rrp_pkg::MAX_LEN_RST;
        end
        else
        begin
            in_full_reg <= in_full_next;
            if (cfg_we)
            begin
                case (rrp_pkg::cfg_index_t'(cfg_index))
                    rrp_pkg::REG_TOK_LIMIT:
                        tok_limit_reg <= cfg_data[rrp_pkg::COUNT_W-1:0];
                    rrp_pkg::REG_MAX_LENGTH:
                        max_length_reg <= cfg_data[rrp_pkg::TOKLEN_W-1:0];
                    default:
                        tok_limit_reg <= tok_limit_reg;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            in_byte_reg <= in_byte;
        end
    end

    rrp_parser #(
        .LENGTH_BITS (LENGTH_BITS)
    ) u_parser (
        .clk        (clk),
        .rst_n      (rst_n),
        .step       (step),
        .in_byte    (in_byte_reg),
        .tok_limit  (tok_limit_reg),
        .max_length (max_length_reg),
        .res_valid  (res_valid),
        .res        (res)
    );

    rrp_out_fifo u_out_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (step && res_valid),
        .push_data (res),
        .has_space (has_space),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

    assign kind         = out_data.kind;
    assign data_byte    = out_data.data_byte;
    assign token_index  = out_data.token_index;
    assign token_length = out_data.token_length;
    assign last_token   = out_data.last_token;
    assign cmd_tokens   = out_data.cmd_tokens;
    assign error_code   = out_data.error_code;

endmodule

// File: tb/sv/tb_resp_request_parser_unit.sv
`timescale 1ns / 1ps

module tb_resp_request_parser_unit;
    import rrp_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 3_000_000;
    localparam int unsigned SETTLE_CYCLES = 8;
    localparam int unsigned PRINT_LIMIT = 40;

    typedef enum
    {
        WAIT_STAR,
        RESYNC,
        COUNT_DIGITS,
        COUNT_LF,
        WANT_DOLLAR,
        LEN_DIGITS,
        LEN_LF,
        PAYLOAD,
        TRAIL1,
        TRAIL2
    } tb_phase_t;

    // Tracks the parser state byte by byte and keeps the words the block owes.
    class resp_parse_model;
        logic [7:0]   tok_limit;
        logic [15:0]  max_len;
        tb_phase_t    phase;
        bit           minus_seen;
        bit           sign_closed;
        int unsigned  acc;
        logic [7:0]   declared;
        logic [7:0]   position;
        logic [15:0]  remaining;
        logic [15:0]  cur_len;
        result_t      pending_words[$];

        function new();
            tok_limit = TOK_LIMIT_RST;
            max_len = MAX_LEN_RST;
            phase = WAIT_STAR;
            minus_seen = 1'b0;
            sign_closed = 1'b0;
            acc = 0;
            declared = '0;
            position = '0;
            remaining = '0;
            cur_len = '0;
        endfunction

        function void open_number();
            minus_seen = 1'b0;
            sign_closed = 1'b0;
            acc = 0;
        endfunction

        function void flag_error(err_t code);
            result_t w;
            w = '0;
            w.kind = KIND_ERROR;
            w.error_code = code;
            pending_words.push_back(w);
            phase = RESYNC;
        endfunction

        // Returns 1 on CR, 0 when the byte joined the number, -1 on a bad byte.
        function int take_digit(logic [7:0] b);
            int unsigned v;
            if (b >= CH_ZERO && b <= CH_NINE)
            begin
                v = acc * 10 + (b - CH_ZERO);
                acc = (v > ACC_MAX) ? ACC_MAX : v;
                sign_closed = 1'b1;
                return 0;
            end
            if (b == CH_MINUS && !sign_closed)
            begin
                minus_seen = 1'b1;
                sign_closed = 1'b1;
                return 0;
            end
            if (b == CH_CR)
                return 1;
            return -1;
        endfunction

        function void note_byte(logic [7:0] b);
            result_t w;
            int      r;
            bit      last;
            w = '0;
            case (phase)
                RESYNC:
                begin
                    if (b == CH_STAR)
                    begin
                        open_number();
                        phase = COUNT_DIGITS;
                    end
                end
                COUNT_DIGITS, LEN_DIGITS:
                begin
                    r = take_digit(b);
                    if (r < 0)
                        flag_error(ERR_BAD_SYNTAX);
                    else if (r > 0)
                        phase = (phase == COUNT_DIGITS) ? COUNT_LF : LEN_LF;
                end
                COUNT_LF:
                begin
                    if (b != CH_LF)
                        flag_error(ERR_BAD_SYNTAX);
                    else if (minus_seen || acc == 0)
                    begin
                        w.kind = KIND_EMPTY;
                        pending_words.push_back(w);
                        phase = WAIT_STAR;
                    end
                    else if (acc > tok_limit)
                        flag_error(ERR_TOO_MANY);
                    else
                    begin
                        declared = acc[7:0];
                        position = '0;
                        phase = WANT_DOLLAR;
                    end
                end
                WANT_DOLLAR:
                begin
                    if (b != CH_DOLLAR)
                        flag_error(ERR_NO_DOLLAR);
                    else
                    begin
                        open_number();
                        phase = LEN_DIGITS;
                    end
                end
                LEN_LF:
                begin
                    if (b != CH_LF)
                        flag_error(ERR_BAD_SYNTAX);
                    else if ((minus_seen && acc != 0) || acc > max_len)
                        flag_error(ERR_BAD_LENGTH);
                    else
                    begin
                        cur_len = acc[15:0];
                        remaining = acc[15:0];
                        phase = (remaining == 0) ? TRAIL1 : PAYLOAD;
                    end
                end
                PAYLOAD:
                begin
                    w.kind = KIND_PAYLOAD;
                    w.data_byte = b;
                    w.token_index = position;
                    w.cmd_tokens = declared;
                    pending_words.push_back(w);
                    remaining = remaining - 16'd1;
                    if (remaining == 0)
                        phase = TRAIL1;
                end
                TRAIL1:
                    phase = TRAIL2;
                TRAIL2:
                begin
                    last = (int'(position) + 1) >= int'(declared);
                    w.kind = KIND_TOKEN_DONE;
                    w.token_index = position;
                    w.token_length = cur_len;
                    w.last_token = last;
                    w.cmd_tokens = declared;
                    pending_words.push_back(w);
                    position = position + 8'd1;
                    phase = last ? WAIT_STAR : WANT_DOLLAR;
                end
                default:
                begin
                    if (b == CH_STAR)
                    begin
                        open_number();
                        phase = COUNT_DIGITS;
                    end
                    else
                        flag_error(ERR_NO_STAR);
                end
            endcase
        endfunction

        // Returns an empty string when the word matches the oldest expectation.
        function string check_word(result_t got);
            result_t want;
            string   msg;
            if (pending_words.size() == 0)
                return $sformatf("word with no expectation: kind %0d", got.kind);
            want = pending_words.pop_front();
            msg = "";
            if (got.kind !== want.kind)
                msg = {msg, $sformatf(" kind %0d want %0d", got.kind, want.kind)};
            if (got.data_byte !== want.data_byte)
                msg = {msg, $sformatf(" data_byte %0h want %0h", got.data_byte, want.data_byte)};
            if (got.token_index !== want.token_index)
                msg = {msg, $sformatf(" token_index %0d want %0d",
                                      got.token_index, want.token_index)};
            if (got.token_length !== want.token_length)
                msg = {msg, $sformatf(" token_length %0d want %0d",
                                      got.token_length, want.token_length)};
            if (got.last_token !== want.last_token)
                msg = {msg, $sformatf(" last_token %0b want %0b",
                                      got.last_token, want.last_token)};
            if (got.cmd_tokens !== want.cmd_tokens)
                msg = {msg, $sformatf(" cmd_tokens %0d want %0d",
                                      got.cmd_tokens, want.cmd_tokens)};
            if (got.error_code !== want.error_code)
                msg = {msg, $sformatf(" error_code %0d want %0d",
                                      got.error_code, want.error_code)};
            return msg;
        endfunction
    endclass

    logic        clk;
    logic        rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic        cfg_index = 1'b0;
    logic [15:0] cfg_data = '0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [7:0]  in_byte = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [1:0]  kind;
    logic [7:0]  data_byte;
    logic [7:0]  token_index;
    logic [15:0] token_length;
    logic        last_token;
    logic [7:0]  cmd_tokens;
    logic [2:0]  error_code;

    resp_parse_model model;
    logic [7:0]      stream_q[$];
    int unsigned     send_idle_pct = 0;
    int unsigned     stall_pct = 0;
    int unsigned     mismatches = 0;
    int unsigned     cycles = 0;

    resp_request_parser_unit i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .in_byte      (in_byte),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .kind         (kind),
        .data_byte    (data_byte),
        .token_index  (token_index),
        .token_length (token_length),
        .last_token   (last_token),
        .cmd_tokens   (cmd_tokens),
        .error_code   (error_code)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    task automatic report_mismatch(input string what);
        mismatches++;
        if (mismatches <= PRINT_LIMIT)
            $display("mismatch at %0t:%s", $time, what);
    endtask

    always @(posedge clk)
    begin
        result_t got;
        string   msg;
        if (rst_n && out_valid && !out_stall)
        begin
            got.kind = kind_t'(kind);
            got.data_byte = data_byte;
            got.token_index = token_index;
            got.token_length = token_length;
            got.last_token = last_token;
            got.cmd_tokens = cmd_tokens;
            got.error_code = err_t'(error_code);
            msg = model.check_word(got);
            if (msg != "")
                report_mismatch(msg);
        end
        out_stall <= rst_n && ($urandom_range(99) < stall_pct);
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("== FAIL ==");
            $finish;
        end
    end

    function automatic void push_text(input string s);
        foreach (s[i])
            stream_q.push_back(s[i]);
    endfunction

    function automatic void push_crlf();
        stream_q.push_back(CH_CR);
        stream_q.push_back(CH_LF);
    endfunction

    // A header or length line: lead byte, number text, CR LF.
    function automatic void push_field(input logic [7:0] lead, input string digits);
        stream_q.push_back(lead);
        push_text(digits);
        push_crlf();
    endfunction

    function automatic void push_request(input int unsigned count, input int unsigned lo,
                                         input int unsigned hi);
        int unsigned len;
        push_field(CH_STAR, $sformatf("%0d", count));
        for (int t = 0; t < count; t++)
        begin
            len = $urandom_range(hi, lo);
            push_field(CH_DOLLAR, $sformatf("%0d", len));
            repeat (len + 2)
                stream_q.push_back(8'($urandom));
        end
    endfunction

    function automatic logic [7:0] odd_byte();
        case ($urandom_range(6))
            0: return CH_STAR;
            1: return CH_DOLLAR;
            2: return CH_CR;
            3: return CH_LF;
            4: return CH_MINUS;
            5: return CH_ZERO + 8'($urandom_range(9));
            default: return 8'($urandom);
        endcase
    endfunction

    function automatic void push_edge_case();
        case ($urandom_range(8))
            0: push_field(CH_STAR, "0");
            1: push_field(CH_STAR, "-7");
            2: push_field(CH_STAR, "");
            3: push_field(CH_STAR, "999999");
            4:
            begin
                push_field(CH_STAR, "1");
                push_field(CH_DOLLAR, "-5");
            end
            5:
            begin
                push_field(CH_STAR, "1");
                push_field(CH_DOLLAR, "-0");
                stream_q.push_back(8'($urandom));
                stream_q.push_back(8'($urandom));
            end
            6:
            begin
                push_field(CH_STAR, "1");
                push_field(CH_DOLLAR, $sformatf("%0d", int'(model.max_len) + 1));
            end
            7: push_field(CH_STAR, "1-");
            default:
            begin
                push_text("*1");
                stream_q.push_back(CH_CR);
                stream_q.push_back(CH_CR);
            end
        endcase
    endfunction

    // Called right after a rising edge; returns right after the edge that took the byte.
    task automatic send_byte(input logic [7:0] b);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_byte <= b;
        do
            @(posedge clk);
        while (in_stall);
        model.note_byte(b);
    endtask

    task automatic send_stream();
        while (stream_q.size() != 0)
            send_byte(stream_q.pop_front());
    endtask

    // Holds the input off until every owed word is out and the pipeline is empty.
    task automatic drain();
        in_valid <= 1'b0;
        while (model.pending_words.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES)
            @(posedge clk);
    endtask

    task automatic configure(input logic [7:0] tokens, input logic [15:0] len);
        cfg_we <= 1'b1;
        cfg_index <= REG_TOK_LIMIT;
        cfg_data <= {8'd0, tokens};
        @(posedge clk);
        cfg_index <= REG_MAX_LENGTH;
        cfg_data <= len;
        @(posedge clk);
        cfg_we <= 1'b0;
        model.tok_limit = tokens;
        model.max_len = len;
    endtask

    task automatic random_phase(input int unsigned budget);
        int unsigned sent;
        int unsigned pick;
        int unsigned count;
        int unsigned len_hi;
        int unsigned cut;
        bit          paused;
        sent = 0;
        paused = 1'b0;
        while (sent < budget)
        begin
            pick = $urandom_range(99);
            if (model.tok_limit == 0)
                count = $urandom_range(3, 1);
            else
                count = $urandom_range((model.tok_limit < 5) ? model.tok_limit : 5, 1);
            if ($urandom_range(19) == 0)
                count = model.tok_limit + 1;
            len_hi = (model.max_len < 10) ? model.max_len : 10;
            if (pick < 85)
            begin
                // An oversized count is refused at the header, so the body is left out.
                if (count > model.tok_limit)
                    push_field(CH_STAR, $sformatf("%0d", count));
                else
                    push_request(count, 0, len_hi);
                if (pick >= 70)
                begin
                    cut = $urandom_range(stream_q.size() - 1, 1);
                    if (pick < 78)
                        stream_q[cut] = odd_byte();
                    else
                        while (stream_q.size() > cut)
                            void'(stream_q.pop_back());
                end
            end
            else if (pick < 93)
                push_edge_case();
            else
                repeat ($urandom_range(4, 1))
                    stream_q.push_back(odd_byte());
            sent += stream_q.size();
            send_stream();
            if (!paused && sent >= budget / 2)
            begin
                drain();
                paused = 1'b1;
            end
        end
        drain();
    endtask

    initial
    begin
        int unsigned idle_send[5]  = '{0, 60, 0, 0, 11};
        int unsigned idle_stall[5] = '{0, 0, 60, 60, 11};
        int unsigned lim_tokens[5] = '{255, 5, 0, 3, 16};
        int unsigned lim_len[5]    = '{65535, 8, 0, 4, 16384};
        int unsigned budget[5]     = '{400, 400, 150, 450, 600};

        model = new();
        repeat (4)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed pass with the limits at their reset values.
        push_text("x!");
        push_field(CH_STAR, "2");
        push_field(CH_DOLLAR, "3");
        stream_q.push_back(8'h00);
        stream_q.push_back(8'hFF);
        stream_q.push_back(CH_STAR);
        push_crlf();
        push_field(CH_DOLLAR, "0");
        stream_q.push_back(8'h55);
        stream_q.push_back(8'hAA);
        push_field(CH_STAR, "0");
        push_field(CH_STAR, "-2");
        push_field(CH_STAR, "");
        push_field(CH_STAR, "1-");
        push_field(CH_STAR, "17");
        push_text("*1");
        stream_q.push_back(CH_CR);
        push_field(CH_STAR, "1");
        push_field(CH_STAR, "1");
        push_text("X");
        push_field(CH_STAR, "1");
        push_text("$1x");
        push_field(CH_STAR, "1");
        push_field(CH_DOLLAR, "-1");
        push_field(CH_STAR, "1");
        push_field(CH_DOLLAR, "16385");
        push_field(CH_STAR, "1");
        push_field(CH_DOLLAR, "99999999");
        push_field(CH_STAR, "1");
        push_field(CH_DOLLAR, "-");
        push_crlf();
        push_field(CH_STAR, "1");
        push_field(CH_DOLLAR, "1");
        push_text("q");
        push_crlf();
        send_stream();
        drain();

        for (int p = 0; p < 5; p++)
        begin
            send_idle_pct = idle_send[p];
            stall_pct = idle_stall[p];
            configure(8'(lim_tokens[p]), 16'(lim_len[p]));
            if (p == 0)
            begin
                // A length one past the 16-bit field.
                push_field(CH_STAR, "1");
                push_field(CH_DOLLAR, "65536");
                send_stream();
            end
            random_phase(budget[p]);
        end

        if (mismatches == 0 && model.pending_words.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
